>>> rtl/wcs_pkg.sv
// shared types and constants of the winnowing cut selector
`default_nettype none

package wcs_pkg;

   localparam int POS_BITS        = 32;
   localparam int HASH_FIELD_BITS = 64;
   localparam int CFG_BITS        = 5;

   localparam logic [CFG_BITS-1:0] CFG_WINDOW_RESET = 5'd4;
   localparam logic [POS_BITS-1:0] POS_MAX          = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_MARK,
      ST_POP,
      ST_FLUSH
   } state_type;

   // per-cycle commands broadcast to every cell
   typedef struct packed {
      logic push;
      logic new_mark;
      logic pop;
      logic set_mark;
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/wcs_cell.sv
// one window cell: holds a hash, its cut mark and stream position, and one stage of the min token
`default_nettype none

module wcs_cell #(
   parameter int HASH_BITS  = 64,
   parameter int MAX_WINDOW = 16,
   parameter int INDEX      = 0,
   localparam int CNT_BITS  = $clog2(MAX_WINDOW + 1),
   localparam int IDX_BITS  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  wire                        clock,
   input  wire  wcs_pkg::cell_ctl_type ctl,
   input  wire  [CNT_BITS-1:0]        fill,
   input  wire  [CNT_BITS-1:0]        start,
   input  wire  [IDX_BITS-1:0]        set_idx,
   input  wire  [HASH_BITS-1:0]       push_hash,
   input  wire  [wcs_pkg::POS_BITS-1:0] push_pos,
   // neighbour on the newer side
   input  wire  [HASH_BITS-1:0]       nb_hash,
   input  wire                        nb_mark,
   input  wire  [wcs_pkg::POS_BITS-1:0] nb_pos,
   input  wire  [HASH_BITS-1:0]       nb_tok_min,
   input  wire  [IDX_BITS-1:0]        nb_tok_idx,
   input  wire                        nb_tok_multi,
   input  wire                        nb_tok_mark,
   output logic [HASH_BITS-1:0]       hash,
   output logic                       mark,
   output logic [wcs_pkg::POS_BITS-1:0] pos,
   output logic [HASH_BITS-1:0]       tok_min,
   output logic [IDX_BITS-1:0]        tok_idx,
   output logic                       tok_multi,
   output logic                       tok_mark
);
   import wcs_pkg::*;

   localparam logic [CNT_BITS-1:0] MY_POS  = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] MY_NEXT = CNT_BITS'(INDEX + 1);
   localparam logic [IDX_BITS-1:0] MY_IDX  = IDX_BITS'(INDEX);

   logic [HASH_BITS-1:0] hash_ff, hash_in;
   logic                 mark_ff, mark_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [HASH_BITS-1:0] tmin_ff, tmin_in;
   logic [IDX_BITS-1:0]  tidx_ff, tidx_in;
   logic                 tmulti_ff, tmulti_in;
   logic                 tmark_ff, tmark_in;

   // entry storage: shift on pop, load on push, set on mark
   always_comb begin
      hash_in = hash_ff;
      mark_in = mark_ff;
      pos_in  = pos_ff;
      if (ctl.pop) begin
         hash_in = nb_hash;
         mark_in = nb_mark;
         pos_in  = nb_pos;
      end else if (ctl.push && (fill == MY_POS)) begin
         hash_in = push_hash;
         mark_in = ctl.new_mark;
         pos_in  = push_pos;
      end else if (ctl.set_mark && (set_idx == MY_IDX)) begin
         mark_in = 1'b1;
      end
   end

   // min token, travelling from the newest entry towards cell 0
   always_comb begin
      tmin_in   = nb_tok_min;
      tidx_in   = nb_tok_idx;
      tmulti_in = nb_tok_multi;
      tmark_in  = nb_tok_mark;
      if (fill == MY_NEXT) begin
         tmin_in   = hash_ff;
         tidx_in   = MY_IDX;
         tmulti_in = 1'b0;
         tmark_in  = mark_ff;
      end else if (MY_POS >= start) begin
         if (hash_ff < nb_tok_min) begin
            tmin_in   = hash_ff;
            tidx_in   = MY_IDX;
            tmulti_in = 1'b0;
            tmark_in  = mark_ff;
         end else if (hash_ff == nb_tok_min) begin
            tmulti_in = 1'b1;
            tmark_in  = nb_tok_mark | mark_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      hash_ff   <= hash_in;
      mark_ff   <= mark_in;
      pos_ff    <= pos_in;
      tmin_ff   <= tmin_in;
      tidx_ff   <= tidx_in;
      tmulti_ff <= tmulti_in;
      tmark_ff  <= tmark_in;
   end

   assign hash      = hash_ff;
   assign mark      = mark_ff;
   assign pos       = pos_ff;
   assign tok_min   = tmin_ff;
   assign tok_idx   = tidx_ff;
   assign tok_multi = tmulti_ff;
   assign tok_mark  = tmark_ff;

endmodule

`default_nettype wire

>>> rtl/winnowing_cut_selector.sv
// top level of the winnowing cut selector: control, chain of window cells and result register
// Each input beat carries one hash; the block keeps the waiting positions in a row of
// MAX_WINDOW cells, oldest in cell 0, and every full window of csr_wdata hashes (0 acts as 1,
// values above MAX_WINDOW as MAX_WINDOW) picks its minimum: a single minimum is marked, tied
// minima mark the rightmost unless one is marked already. A position leaves as a result beat
// (position, cut flag, tlast on the final flush beat) once no later window can reach it; the
// last input beat flushes everything and restarts positions at 0, and a document of at most
// W hashes marks only its final position. One item is in work at a time: the input beat is
// taken in the idle state, the evaluation state lets the min token ride down the cell chain
// to cell 0, the marking state marks the chosen minimum, and the result beats then leave one
// per cycle while the result register is free. The result register lets the next item enter
// while the last result beat is still waiting.
`default_nettype none

module winnowing_cut_selector #(
   parameter int MAX_WINDOW = 16,
   parameter int HASH_BITS  = 64
) (
   input  wire         clock,
   input  wire         reset,
   // configuration: window_size
   input  wire         csr_wen,
   input  wire  [4:0]  csr_wdata,
   // input beats
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [63:0] hash_value
   input  wire         req_tlast,   // last_item
   // result beats
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] position
   output logic        rsp_tuser,   // cut_here
   output logic        rsp_tlast    // last_result
);
   import wcs_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int IDX_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // control state
   state_type             state_ff, state_in;
   logic [CFG_BITS-1:0]   window_ff;
   logic [CNT_BITS-1:0]   fill_ff, fill_in;
   logic [CNT_BITS-1:0]   win_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  last_ff;
   logic [POS_BITS-1:0]   next_pos_ff, next_pos_in;

   // result register
   logic                  rsp_valid_ff;
   logic [POS_BITS-1:0]   rsp_pos_ff;
   logic                  rsp_cut_ff;
   logic                  rsp_last_ff;

   logic [CNT_BITS-1:0]   eff_w;
   logic [CNT_BITS-1:0]   fill_plus;
   logic [CNT_BITS-1:0]   start;
   logic                  accept;
   logic                  short_doc;
   logic                  out_free;
   logic                  do_pop;
   logic                  pop_last;
   cell_ctl_type          ctl;

   // cell chain, index MAX_WINDOW is the empty end beyond the newest cell
   logic [HASH_BITS-1:0]  c_hash  [MAX_WINDOW+1];
   logic                  c_mark  [MAX_WINDOW+1];
   logic [POS_BITS-1:0]   c_pos   [MAX_WINDOW+1];
   logic [HASH_BITS-1:0]  c_tmin  [MAX_WINDOW+1];
   logic [IDX_BITS-1:0]   c_tidx  [MAX_WINDOW+1];
   logic                  c_tmulti[MAX_WINDOW+1];
   logic                  c_tmark [MAX_WINDOW+1];

   // effective window length, clamped to 1..MAX_WINDOW
   always_comb begin
      int wv;
      wv = int'(window_ff);
      if (wv < 1)          wv = 1;
      if (wv > MAX_WINDOW) wv = MAX_WINDOW;
      eff_w = CNT_BITS'(wv);
   end

   assign fill_plus = fill_ff + CNT_BITS'(1);
   assign start     = fill_ff - win_ff;
   assign accept    = req_tvalid && req_tready;
   // document of at most W hashes ends here
   assign short_doc = req_tlast && (next_pos_ff < POS_BITS'(eff_w));
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // fsm outputs
   always_comb begin
      req_tready   = 1'b0;
      ctl          = '0;
      do_pop       = 1'b0;
      pop_last     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            ctl.push     = req_tvalid;
            ctl.new_mark = short_doc;
         end
         ST_EVAL: begin
         end
         ST_MARK: begin
            // tied minima with one already marked leave the marks alone
            ctl.set_mark = !(c_tmulti[0] && c_tmark[0]);
         end
         ST_POP: begin
            do_pop = (fill_ff >= win_ff) && out_free;
         end
         ST_FLUSH: begin
            do_pop   = (fill_ff != '0) && out_free;
            pop_last = (fill_ff == CNT_BITS'(1));
         end
         default: begin
         end
      endcase
      ctl.pop = do_pop;
   end

   // fsm next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (short_doc)               state_in = ST_FLUSH;
               else if (fill_plus >= eff_w) state_in = ST_EVAL;
               else if (req_tlast)          state_in = ST_FLUSH;
            end
         end
         ST_EVAL: begin
            if (count_ff == CNT_BITS'(1)) state_in = ST_MARK;
         end
         ST_MARK: begin
            state_in = ST_POP;
         end
         ST_POP: begin
            if (fill_ff < win_ff) state_in = last_ff ? ST_FLUSH : ST_IDLE;
         end
         ST_FLUSH: begin
            if (fill_ff == '0) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // counters and position
   always_comb begin
      fill_in     = fill_ff;
      count_in    = count_ff;
      next_pos_in = next_pos_ff;
      if (accept) begin
         fill_in  = fill_plus;
         count_in = fill_plus;
         if (req_tlast)                  next_pos_in = '0;
         else if (next_pos_ff != POS_MAX) next_pos_in = next_pos_ff + POS_BITS'(1);
      end else if (do_pop) begin
         fill_in = fill_ff - CNT_BITS'(1);
      end
      if (state_ff == ST_EVAL) count_in = count_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         window_ff   <= CFG_WINDOW_RESET;
         fill_ff     <= '0;
         count_ff    <= '0;
         win_ff      <= '0;
         last_ff     <= 1'b0;
         next_pos_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         next_pos_ff <= next_pos_in;
         if (csr_wen) window_ff <= csr_wdata;
         if (accept) begin
            win_ff  <= eff_w;
            last_ff <= req_tlast;
         end
      end
   end

   // result register, loaded from cell 0 as it shifts out
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_pop) begin
         rsp_pos_ff  <= c_pos[0];
         rsp_cut_ff  <= c_mark[0];
         rsp_last_ff <= pop_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pos_ff;
   assign rsp_tuser  = rsp_cut_ff;
   assign rsp_tlast  = rsp_last_ff;

   // empty end of the chain
   assign c_hash[MAX_WINDOW]   = '0;
   assign c_mark[MAX_WINDOW]   = 1'b0;
   assign c_pos[MAX_WINDOW]    = '0;
   assign c_tmin[MAX_WINDOW]   = '0;
   assign c_tidx[MAX_WINDOW]   = '0;
   assign c_tmulti[MAX_WINDOW] = 1'b0;
   assign c_tmark[MAX_WINDOW]  = 1'b0;

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      wcs_cell #(
         .HASH_BITS  (HASH_BITS),
         .MAX_WINDOW (MAX_WINDOW),
         .INDEX      (i)
      ) u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .fill         (fill_ff),
         .start        (start),
         .set_idx      (c_tidx[0]),
         .push_hash    (req_tdata[HASH_BITS-1:0]),
         .push_pos     (next_pos_ff),
         .nb_hash      (c_hash[i+1]),
         .nb_mark      (c_mark[i+1]),
         .nb_pos       (c_pos[i+1]),
         .nb_tok_min   (c_tmin[i+1]),
         .nb_tok_idx   (c_tidx[i+1]),
         .nb_tok_multi (c_tmulti[i+1]),
         .nb_tok_mark  (c_tmark[i+1]),
         .hash         (c_hash[i]),
         .mark         (c_mark[i]),
         .pos          (c_pos[i]),
         .tok_min      (c_tmin[i]),
         .tok_idx      (c_tidx[i]),
         .tok_multi    (c_tmulti[i]),
         .tok_mark     (c_tmark[i])
      );
   end

   // the cell row never overflows
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      int'(fill_ff) <= MAX_WINDOW)
      else $error("fill count beyond the cell row");

   // a short document goes straight to the flush
   a_short_flush: assert property (@(posedge clock) disable iff (reset)
      accept && short_doc |=> state_ff == ST_FLUSH)
      else $error("short document did not flush");

   // the flagged final beat empties the row
   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      do_pop && pop_last |=> fill_ff == '0)
      else $error("final result left entries behind");

   // marking only happens over a full window
   a_mark_full: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> fill_ff >= win_ff)
      else $error("window marked while not full");

endmodule

`default_nettype wire

>>> bench/winnowing_cut_selector_checker.sv
// checker of the winnowing cut selector: watches both channels, predicts cut decisions, compares
module winnowing_cut_selector_checker #(
   parameter int MAX_WINDOW = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wen,
   input  wire  [wcs_pkg::CFG_BITS-1:0]        csr_wdata,
   input  wire                                 req_tvalid,
   input  wire                                 req_tready,
   input  wire  [wcs_pkg::HASH_FIELD_BITS-1:0] req_tdata,
   input  wire                                 req_tlast,
   input  wire                                 rsp_tvalid,
   input  wire                                 rsp_tready,
   input  wire  [wcs_pkg::POS_BITS-1:0]        rsp_tdata,
   input  wire                                 rsp_tuser,
   input  wire                                 rsp_tlast,
   output int                                  fail_count,
   output int                                  outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import wcs_pkg::*;

   typedef struct packed {
      logic [POS_BITS-1:0] position;
      logic                cut_here;
      logic                last_result;
   } decision_type;

   logic [CFG_BITS-1:0]        window_reg;
   logic [HASH_FIELD_BITS-1:0] held_hash [MAX_WINDOW];
   logic                       held_mark [MAX_WINDOW];
   logic [POS_BITS-1:0]        held_pos  [MAX_WINDOW];
   int                         held_count;
   logic [POS_BITS-1:0]        pos_counter;
   decision_type               decisions_due [$];
   int                         errors = 0;

   // zero acts as one, anything above the cell count as the cell count
   function automatic int window_span();
      int w;
      w = int'(window_reg);
      if (w < 1) w = 1;
      if (w > MAX_WINDOW) w = MAX_WINDOW;
      return w;
   endfunction

   task automatic retire_oldest(input logic last_flag);
      decision_type d;
      d.position    = held_pos[0];
      d.cut_here    = held_mark[0];
      d.last_result = last_flag;
      decisions_due = {decisions_due, d};
      for (int i = 1; i < held_count; i++) begin
         held_hash[i-1] = held_hash[i];
         held_mark[i-1] = held_mark[i];
         held_pos[i-1]  = held_pos[i];
      end
      held_count--;
   endtask

   // newest w entries form the window; tied minima mark the rightmost unless one is marked
   task automatic choose_minimum(input int w);
      int                         first;
      int                         ties;
      int                         rightmost;
      logic                       any_marked;
      logic [HASH_FIELD_BITS-1:0] lowest;
      first      = held_count - w;
      ties       = 0;
      rightmost  = first;
      any_marked = 1'b0;
      lowest     = held_hash[first];
      for (int i = first + 1; i < held_count; i++)
         if (held_hash[i] < lowest) lowest = held_hash[i];
      for (int i = first; i < held_count; i++) begin
         if (held_hash[i] == lowest) begin
            ties++;
            rightmost = i;
            if (held_mark[i]) any_marked = 1'b1;
         end
      end
      if (ties == 1 || !any_marked) held_mark[rightmost] = 1'b1;
   endtask

   task automatic take_hash(input logic [HASH_FIELD_BITS-1:0] h, input logic final_item);
      int                  w;
      logic [POS_BITS-1:0] pos;
      logic [POS_BITS:0]   doc_len;
      w   = window_span();
      pos = pos_counter;
      if (held_count >= MAX_WINDOW) held_count = MAX_WINDOW - 1;
      held_hash[held_count] = h;
      held_mark[held_count] = 1'b0;
      held_pos[held_count]  = pos;
      held_count++;
      if (pos_counter != POS_MAX) pos_counter++;
      doc_len = {1'b0, pos} + 1'b1;
      if (final_item && doc_len <= w) begin
         held_mark[held_count-1] = 1'b1;
      end else if (held_count >= w) begin
         choose_minimum(w);
         while (held_count > w - 1) retire_oldest(1'b0);
      end
      if (final_item) begin
         while (held_count > 0) retire_oldest(held_count == 1);
         pos_counter = '0;
      end
   endtask

   task automatic check_decision();
      decision_type seen;
      decision_type due;
      seen.position    = rsp_tdata;
      seen.cut_here    = rsp_tuser;
      seen.last_result = rsp_tlast;
      if (decisions_due.size() == 0) begin
         errors++;
         $display("%0t: unexpected result beat: expected none, %s %h cut %b last %b",
                  $time, "actual pos", seen.position, seen.cut_here, seen.last_result);
      end else begin
         due = decisions_due.pop_front();
         if (seen !== due) begin
            errors++;
            $display("%0t: result mismatch: expected pos %h cut %b last %b, %s %h cut %b last %b",
                     $time, due.position, due.cut_here, due.last_result,
                     "actual pos", seen.position, seen.cut_here, seen.last_result);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_reg  = CFG_WINDOW_RESET;
         held_count  = 0;
         pos_counter = '0;
         for (int i = 0; i < MAX_WINDOW; i++) begin
            held_hash[i] = '0;
            held_mark[i] = 1'b0;
            held_pos[i]  = '0;
         end
         decisions_due.delete();
      end else begin
         if (rsp_tvalid === 1'b1 && rsp_tready) check_decision();
         if (csr_wen) window_reg = csr_wdata;
         if (req_tvalid && req_tready === 1'b1) take_hash(req_tdata, req_tlast);
      end
      fail_count  <= errors;
      outstanding <= decisions_due.size();
   end

endmodule

>>> bench/winnowing_cut_selector_tb.sv
// testbench top of the winnowing cut selector: clock, reset, stimulus and verdict
module winnowing_cut_selector_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcs_pkg::*;

   localparam int MAX_WINDOW = 16;
   localparam int SETTLE_CYCLES = 40;   // wait after the last expected result has left, with margin
   localparam int HOLD_CYCLES = 300;    // long receiver hold-off that backs up the block

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wen = 1'b0;
   logic [4:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // [63:0] hash_value
   logic        req_tlast = 1'b0; // last_item
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] position
   logic        rsp_tuser;        // cut_here
   logic        rsp_tlast;        // last_result

   int fail_count;
   int outstanding;

   // idling chances in percent, the receiver's one is read by its own process
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // hold-off requests from the stimulus, served by the receiver process
   int hold_requests = 0;
   int holds_granted = 0;
   int hold_left = 0;

   // remaining beats of the document under way
   int doc_left = 0;

   winnowing_cut_selector #(
      .MAX_WINDOW (MAX_WINDOW),
      .HASH_BITS  (64)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   winnowing_cut_selector_checker #(
      .MAX_WINDOW (MAX_WINDOW)
   ) cut_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: a pending hold-off request wins, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_granted != hold_requests) begin
         rsp_tready    <= 1'b0;
         hold_left     <= HOLD_CYCLES;
         holds_granted <= holds_granted + 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // offer one beat, with random idle cycles in front, and wait for it to be taken
   task automatic send_item(input logic [63:0] h, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= h;
      req_tlast  <= l;
      do @(posedge clock); while (req_tready !== 1'b1);
   endtask

   // wait until every predicted result has left, then let the block run dry
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0 && guard < 50000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // window size is only changed with the block idle, documents may still be open
   task automatic write_window(input logic [4:0] value);
      settle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   // small values breed ties, the rest covers every hash bit and the extremes
   function automatic logic [63:0] pick_hash();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 64'($urandom_range(0, 7));
         4, 5, 6:    return {$urandom, $urandom};
         7:          return '1;
         8:          return '0;
         default:    return 64'hFFFF_FFFF_FFFF_FFF0 | 64'($urandom_range(0, 3));
      endcase
   endfunction

   // documents of mostly moderate length, some short ones and some long ones
   task automatic send_random_item();
      if (doc_left == 0) begin
         case ($urandom_range(0, 9))
            0, 1:    doc_left = $urandom_range(1, 5);
            8, 9:    doc_left = $urandom_range(25, 60);
            default: doc_left = $urandom_range(6, 24);
         endcase
      end
      send_item(pick_hash(), doc_left == 1);
      doc_left--;
   endtask

   task automatic run_phase(input logic [4:0] window, input int send_pct, input int recv_pct,
                            input int items, input bit long_hold);
      write_window(window);
      send_idle_pct = send_pct;
      recv_stall_pct <= recv_pct;
      if (long_hold) hold_requests <= hold_requests + 1;
      repeat (items) send_random_item();
   endtask

   logic [63:0] tie_run [10] = '{
      64'd5, 64'd5, 64'd5, 64'd5, 64'd3, 64'd3,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, '1, '0
   };

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset window of four, single-beat document
      send_item('0, 1'b1);
      // short document of three, extreme hashes
      send_item('1, 1'b0);
      send_item('0, 1'b0);
      send_item('1, 1'b1);
      // tied minima, marked and unmarked, then both extremes
      foreach (tie_run[i]) send_item(tie_run[i], i == 9);
      // window size zero acts as one
      write_window(5'd0);
      send_item(64'd7, 1'b0);
      send_item(64'd7, 1'b0);
      send_item('0, 1'b0);
      send_item('1, 1'b1);
      // oversized window saturates, so five beats still make a short document
      write_window(5'd31);
      send_item(64'd9, 1'b0);
      send_item(64'd2, 1'b0);
      send_item(64'd2, 1'b0);
      send_item('1, 1'b0);
      send_item('0, 1'b1);

      // random phases, documents run on across window changes
      run_phase(5'd4, 0, 0, 24, 1'b1);
      run_phase(5'd1, 74, 0, 20, 1'b0);
      run_phase(5'd16, 0, 74, 24, 1'b0);
      run_phase(5'd0, 33, 33, 14, 1'b0);
      run_phase(5'd31, 0, 0, 18, 1'b0);
      run_phase(5'($urandom_range(2, 15)), 33, 33, 19, 1'b0);
      run_phase(5'($urandom_range(0, 31)), 74, 0, 19, 1'b0);

      settle();
      if (outstanding != 0)
         $display("%0t: %0d expected results never arrived", $time, outstanding);
      if (fail_count == 0 && outstanding == 0) begin
         $display("[winnowing_cut_selector] OK");
      end else begin
         $display("[winnowing_cut_selector] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("[winnowing_cut_selector] ERROR");
      $finish;
   end

endmodule

>>> sim.f
rtl/wcs_pkg.sv
rtl/wcs_cell.sv
rtl/winnowing_cut_selector.sv
bench/winnowing_cut_selector_checker.sv
bench/winnowing_cut_selector_tb.sv
